/* src/abag_pkg.sv */
// Shared types, widths and helpers for the affine background address generator.
`default_nettype none
package abag_pkg;

  localparam int unsigned LINE_W   = 8;
  localparam int unsigned COL_W    = 8;
  localparam int unsigned IN_W     = LINE_W + COL_W;
  localparam int unsigned MAP_W    = 14;
  localparam int unsigned TEXEL_W  = 6;
  localparam int unsigned OUT_W    = MAP_W + TEXEL_W + 4;
  localparam int unsigned MATRIX_W = 16;
  localparam int unsigned CENTER_W = 13;
  localparam int unsigned SCROLL_W = 26;
  localparam int unsigned MODE_W   = 9;
  localparam int unsigned CFG_W    = 26;
  localparam int unsigned CFG_IDX_W = 3;

  // Offset after the 13-bit wrap: 11-bit signed.
  localparam int unsigned OFS_W    = 11;
  // Matrix times wrapped offset, matrix times screen coordinate.
  localparam int unsigned PROD_OFS_W = MATRIX_W + OFS_W;
  localparam int unsigned PROD_SCR_W = MATRIX_W + 9;
  // Position sum with 8 fraction bits, and its integer part.
  localparam int unsigned SUM_W    = 29;
  localparam int unsigned POS_W    = SUM_W - 8;

  // Remainder of the mosaic restoring division (divisor 1..16).
  localparam int unsigned REM_W    = 4;
  localparam int unsigned DIV_W    = 5;

  // Screen and map geometry.
  localparam logic [LINE_W-1:0] SCREEN_LAST = 8'd255;

  // Mode control bit positions.
  localparam int unsigned MODE_HFLIP  = 0;
  localparam int unsigned MODE_VFLIP  = 1;
  localparam int unsigned MODE_RPT_LO = 2;
  localparam int unsigned MODE_MOSAIC = 4;
  localparam int unsigned MODE_SIZE_LO = 5;

  typedef enum logic [1:0] {
    RPT_WRAP0       = 2'd0,
    RPT_WRAP1       = 2'd1,
    RPT_TRANSPARENT = 2'd2,
    RPT_TILE_ZERO   = 2'd3
  } repeat_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATRIX_A  = 3'd0,
    REG_MATRIX_B  = 3'd1,
    REG_MATRIX_C  = 3'd2,
    REG_MATRIX_D  = 3'd3,
    REG_CENTER_H  = 3'd4,
    REG_CENTER_V  = 3'd5,
    REG_SCROLL    = 3'd6,
    REG_MODE      = 3'd7
  } cfg_reg_t;

  // One restoring step of remainder: shift in a dividend bit, subtract if it fits.
  function automatic logic [REM_W-1:0] mod_step(input logic [REM_W-1:0] rem,
                                                input logic            bit_in,
                                                input logic [DIV_W-1:0] divisor);
    logic [DIV_W-1:0] t;
    t = {rem, bit_in};
    if (t >= divisor) begin
      t = t - divisor;
    end
    return t[REM_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* src/affine_background_address_generator_core.sv */
// Top level: pipelined affine (rotate/scale) background address generator.
`default_nettype none
// One screen pixel per beat enters on the s_ side (line and column) and one
// address beat leaves on the m_ side: tile-map word address, texel index in the
// 8x8 character, out-of-bounds flag, repeat-mode flags and the mosaic sample
// flag. The block takes a new pixel every clock while the output is not stalled;
// an accepted beat passes through every register stage on its way to m_tvalid. The five
// register stages are: the high half of the mosaic remainders with the wrapped
// offsets, the low half (a four-step restoring division each) with the flips
// and the matrix-times-offset products, the matrix-times-screen products, the
// position sum, and the output register.
// Back pressure on m_tready holds every stage at once, so nothing is lost or
// repeated. Configuration writes (cfg_we, cfg_index, cfg_data) take effect at
// the next edge and are to be made only with the pipeline empty.
module affine_background_address_generator_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // config write port
  input  wire logic                           cfg_we,
  input  wire logic [abag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [abag_pkg::CFG_W-1:0]     cfg_data,
  // pixel input
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [abag_pkg::IN_W-1:0]      s_tdata,   // [7:0] screen_line, [15:8] screen_column
  // address output
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [abag_pkg::OUT_W-1:0]          m_tdata    // [13:0] map_address, [19:14] texel_index,
                                                         // [20] out_of_bounds, [21] use_tile_zero,
                                                         // [22] force_transparent, [23] mosaic_sample
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [abag_pkg::MATRIX_W-1:0] matrix_a;
  logic [abag_pkg::MATRIX_W-1:0] matrix_b;
  logic [abag_pkg::MATRIX_W-1:0] matrix_c;
  logic [abag_pkg::MATRIX_W-1:0] matrix_d;
  logic [abag_pkg::CENTER_W-1:0] center_horizontal;
  logic [abag_pkg::CENTER_W-1:0] center_vertical;
  logic [abag_pkg::SCROLL_W-1:0] scroll_offset;
  logic [abag_pkg::MODE_W-1:0]   mode_control;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_a          <= '0;
      matrix_b          <= '0;
      matrix_c          <= '0;
      matrix_d          <= '0;
      center_horizontal <= '0;
      center_vertical   <= '0;
      scroll_offset     <= '0;
      mode_control      <= '0;
    end else if (cfg_we) begin
      unique case (abag_pkg::cfg_reg_t'(cfg_index))
        abag_pkg::REG_MATRIX_A: matrix_a          <= cfg_data[abag_pkg::MATRIX_W-1:0];
        abag_pkg::REG_MATRIX_B: matrix_b          <= cfg_data[abag_pkg::MATRIX_W-1:0];
        abag_pkg::REG_MATRIX_C: matrix_c          <= cfg_data[abag_pkg::MATRIX_W-1:0];
        abag_pkg::REG_MATRIX_D: matrix_d          <= cfg_data[abag_pkg::MATRIX_W-1:0];
        abag_pkg::REG_CENTER_H: center_horizontal <= cfg_data[abag_pkg::CENTER_W-1:0];
        abag_pkg::REG_CENTER_V: center_vertical   <= cfg_data[abag_pkg::CENTER_W-1:0];
        abag_pkg::REG_SCROLL:   scroll_offset     <= cfg_data[abag_pkg::SCROLL_W-1:0];
        abag_pkg::REG_MODE:     mode_control      <= cfg_data[abag_pkg::MODE_W-1:0];
      endcase
    end
  end

  // Decoded mode fields.
  logic                        hflip;
  logic                        vflip;
  logic                        mosaic_en;
  logic [1:0]                  repeat_mode;
  logic [abag_pkg::DIV_W-1:0]  mosaic_div;

  assign hflip       = mode_control[abag_pkg::MODE_HFLIP];
  assign vflip       = mode_control[abag_pkg::MODE_VFLIP];
  assign mosaic_en   = mode_control[abag_pkg::MODE_MOSAIC];
  assign repeat_mode = mode_control[abag_pkg::MODE_RPT_LO +: 2];
  // mosaic size field holds size minus one
  assign mosaic_div  = {1'b0, mode_control[abag_pkg::MODE_SIZE_LO +: 4]} + 5'd1;

  // ---------------------------------------------------------------------------
  // Pipeline enable: every stage advances together unless the output is stuck.
  // ---------------------------------------------------------------------------
  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // ---------------------------------------------------------------------------
  // Stage 1: high half of the mosaic remainders, wrapped offsets
  // ---------------------------------------------------------------------------
  logic                               v1;
  logic [abag_pkg::LINE_W-1:0]        s1_line;
  logic [abag_pkg::COL_W-1:0]         s1_col;
  logic [abag_pkg::REM_W-1:0]         s1_lrem;
  logic [abag_pkg::REM_W-1:0]         s1_crem;
  logic signed [abag_pkg::OFS_W-1:0]  s1_dh;
  logic signed [abag_pkg::OFS_W-1:0]  s1_dv;

  logic [abag_pkg::LINE_W-1:0]        in_line;
  logic [abag_pkg::COL_W-1:0]         in_col;
  logic [abag_pkg::REM_W-1:0]         lrem_hi;
  logic [abag_pkg::REM_W-1:0]         crem_hi;
  logic signed [13:0]                 diff_h;
  logic signed [13:0]                 diff_v;

  assign in_line = s_tdata[abag_pkg::LINE_W-1:0];
  assign in_col  = s_tdata[abag_pkg::IN_W-1:abag_pkg::LINE_W];

  always_comb begin
    lrem_hi = '0;
    crem_hi = '0;
    for (int i = 7; i >= 4; i--) begin
      lrem_hi = abag_pkg::mod_step(lrem_hi, in_line[i], mosaic_div);
      crem_hi = abag_pkg::mod_step(crem_hi, in_col[i], mosaic_div);
    end
  end

  // scroll minus center, then keep bit 13 as sign over the low ten bits
  assign diff_h = $signed({scroll_offset[12], scroll_offset[12:0]})
                - $signed({center_horizontal[12], center_horizontal});
  assign diff_v = $signed({scroll_offset[25], scroll_offset[25:13]})
                - $signed({center_vertical[12], center_vertical});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_line <= in_line;
      s1_col  <= in_col;
      s1_lrem <= lrem_hi;
      s1_crem <= crem_hi;
      s1_dh   <= $signed({diff_h[13], diff_h[9:0]});
      s1_dv   <= $signed({diff_v[13], diff_v[9:0]});
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: finish remainders, mosaic and flips, matrix times offsets
  // ---------------------------------------------------------------------------
  logic                                    v2;
  logic [abag_pkg::LINE_W-1:0]             s2_y;
  logic [abag_pkg::COL_W-1:0]              s2_x;
  logic                                    s2_sample;
  logic signed [abag_pkg::PROD_OFS_W-1:0]  s2_pah;
  logic signed [abag_pkg::PROD_OFS_W-1:0]  s2_pbv;
  logic signed [abag_pkg::PROD_OFS_W-1:0]  s2_pch;
  logic signed [abag_pkg::PROD_OFS_W-1:0]  s2_pdv;

  logic [abag_pkg::REM_W-1:0]              lrem;
  logic [abag_pkg::REM_W-1:0]              crem;
  logic [abag_pkg::LINE_W-1:0]             mos_line;
  logic signed [abag_pkg::PROD_OFS_W-1:0]  p_ah;
  logic signed [abag_pkg::PROD_OFS_W-1:0]  p_bv;
  logic signed [abag_pkg::PROD_OFS_W-1:0]  p_ch;
  logic signed [abag_pkg::PROD_OFS_W-1:0]  p_dv;

  always_comb begin
    lrem = s1_lrem;
    crem = s1_crem;
    for (int i = 3; i >= 0; i--) begin
      lrem = abag_pkg::mod_step(lrem, s1_line[i], mosaic_div);
      crem = abag_pkg::mod_step(crem, s1_col[i], mosaic_div);
    end
  end

  // round the line down to a multiple of the mosaic size
  assign mos_line = mosaic_en ? (s1_line - {4'd0, lrem}) : s1_line;

  assign p_ah = $signed(matrix_a) * s1_dh;
  assign p_bv = $signed(matrix_b) * s1_dv;
  assign p_ch = $signed(matrix_c) * s1_dh;
  assign p_dv = $signed(matrix_d) * s1_dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_y      <= vflip ? (abag_pkg::SCREEN_LAST - mos_line) : mos_line;
      s2_x      <= hflip ? (abag_pkg::SCREEN_LAST - s1_col) : s1_col;
      s2_sample <= !mosaic_en || (crem == '0);
      // drop the low six bits of each partial product (floor to 64)
      s2_pah    <= {p_ah[abag_pkg::PROD_OFS_W-1:6], 6'd0};
      s2_pbv    <= {p_bv[abag_pkg::PROD_OFS_W-1:6], 6'd0};
      s2_pch    <= {p_ch[abag_pkg::PROD_OFS_W-1:6], 6'd0};
      s2_pdv    <= {p_dv[abag_pkg::PROD_OFS_W-1:6], 6'd0};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: matrix times screen coordinates, offset terms summed
  // ---------------------------------------------------------------------------
  logic                                      v3;
  logic                                      s3_sample;
  logic signed [abag_pkg::PROD_SCR_W-1:0]    s3_ax;
  logic signed [abag_pkg::PROD_SCR_W-1:0]    s3_cx;
  logic signed [abag_pkg::PROD_SCR_W-1:0]    s3_by;
  logic signed [abag_pkg::PROD_SCR_W-1:0]    s3_dy;
  logic signed [abag_pkg::PROD_OFS_W:0]      s3_kx;
  logic signed [abag_pkg::PROD_OFS_W:0]      s3_ky;

  logic signed [abag_pkg::PROD_SCR_W-1:0]    p_ax;
  logic signed [abag_pkg::PROD_SCR_W-1:0]    p_cx;
  logic signed [abag_pkg::PROD_SCR_W-1:0]    p_by;
  logic signed [abag_pkg::PROD_SCR_W-1:0]    p_dy;

  assign p_ax = $signed(matrix_a) * $signed({1'b0, s2_x});
  assign p_cx = $signed(matrix_c) * $signed({1'b0, s2_x});
  assign p_by = $signed(matrix_b) * $signed({1'b0, s2_y});
  assign p_dy = $signed(matrix_d) * $signed({1'b0, s2_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ce) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s3_sample <= s2_sample;
      s3_ax     <= p_ax;
      s3_cx     <= p_cx;
      s3_by     <= {p_by[abag_pkg::PROD_SCR_W-1:6], 6'd0};
      s3_dy     <= {p_dy[abag_pkg::PROD_SCR_W-1:6], 6'd0};
      s3_kx     <= (abag_pkg::PROD_OFS_W+1)'(s2_pah) + (abag_pkg::PROD_OFS_W+1)'(s2_pbv);
      s3_ky     <= (abag_pkg::PROD_OFS_W+1)'(s2_pch) + (abag_pkg::PROD_OFS_W+1)'(s2_pdv);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: position sums, integer part kept (floor by 256)
  // ---------------------------------------------------------------------------
  logic                                 v4;
  logic                                 s4_sample;
  logic signed [abag_pkg::POS_W-1:0]    s4_px;
  logic signed [abag_pkg::POS_W-1:0]    s4_py;

  logic signed [abag_pkg::SUM_W-1:0]    sum_x;
  logic signed [abag_pkg::SUM_W-1:0]    sum_y;
  logic signed [20:0]                   hc_scaled;
  logic signed [20:0]                   vc_scaled;

  assign hc_scaled = $signed({center_horizontal, 8'd0});
  assign vc_scaled = $signed({center_vertical, 8'd0});

  assign sum_x = abag_pkg::SUM_W'(s3_kx) + abag_pkg::SUM_W'(s3_by)
               + abag_pkg::SUM_W'(hc_scaled) + abag_pkg::SUM_W'(s3_ax);
  assign sum_y = abag_pkg::SUM_W'(s3_ky) + abag_pkg::SUM_W'(s3_dy)
               + abag_pkg::SUM_W'(vc_scaled) + abag_pkg::SUM_W'(s3_cx);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ce) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s4_sample <= s3_sample;
      s4_px     <= sum_x[abag_pkg::SUM_W-1:8];
      s4_py     <= sum_y[abag_pkg::SUM_W-1:8];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: address split and flags into the output register
  // ---------------------------------------------------------------------------
  logic [abag_pkg::MAP_W-1:0]   map_address;
  logic [abag_pkg::TEXEL_W-1:0] texel_index;
  logic                         out_of_bounds;
  logic                         use_tile_zero;
  logic                         force_transparent;

  // wrapped address still given when out of the 1024x1024 field
  assign map_address       = {s4_py[9:3], s4_px[9:3]};
  assign texel_index       = {s4_py[2:0], s4_px[2:0]};
  assign out_of_bounds     = (s4_px[abag_pkg::POS_W-1:10] != '0)
                          || (s4_py[abag_pkg::POS_W-1:10] != '0);
  assign use_tile_zero     = out_of_bounds && (repeat_mode == abag_pkg::RPT_TILE_ZERO);
  assign force_transparent = out_of_bounds && (repeat_mode == abag_pkg::RPT_TRANSPARENT);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= {s4_sample, force_transparent, use_tile_zero, out_of_bounds,
                  texel_index, map_address};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // input stalls only when a finished beat is held at the output
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output back pressure");

  // an accepted pixel always lands in the first stage
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v1)
    else $error("accepted pixel lost at stage 1");

  // a held stage keeps its valid bit
  assert property (@(posedge clk) disable iff (rst)
    (v4 && !ce) |=> v4)
    else $error("stage 4 beat dropped while stalled");

  // with mosaic off every column samples
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !mosaic_en) |-> m_tdata[23])
    else $error("mosaic sample cleared with mosaic disabled");

  // repeat flags are exclusive
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[21] && m_tdata[22]))
    else $error("both repeat flags set");

endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the affine background address generator core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_PIXELS   = 44;
  localparam longint LOW6_MASK  = 63;
  localparam longint FIELD_MASK = 1023;

  // One expected address beat, field by field.
  typedef struct {
    logic [abag_pkg::MAP_W-1:0]   map_address;
    logic [abag_pkg::TEXEL_W-1:0] texel_index;
    logic                         out_of_bounds;
    logic                         use_tile_zero;
    logic                         force_transparent;
    logic                         mosaic_sample;
  } texel_addr_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [abag_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [abag_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [abag_pkg::IN_W-1:0]      s_tdata = '0;   // [7:0] screen_line, [15:8] screen_column
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [abag_pkg::OUT_W-1:0]     m_tdata;        // [13:0] map_address, [19:14] texel_index,
                                                  // [20] out_of_bounds, [21] use_tile_zero,
                                                  // [22] force_transparent, [23] mosaic_sample

  // Shadow copy of the register file, updated as each write goes out.
  logic signed [abag_pkg::MATRIX_W-1:0] mat_a = '0;
  logic signed [abag_pkg::MATRIX_W-1:0] mat_b = '0;
  logic signed [abag_pkg::MATRIX_W-1:0] mat_c = '0;
  logic signed [abag_pkg::MATRIX_W-1:0] mat_d = '0;
  logic signed [abag_pkg::CENTER_W-1:0] ctr_h = '0;
  logic signed [abag_pkg::CENTER_W-1:0] ctr_v = '0;
  logic [abag_pkg::SCROLL_W-1:0]        scroll_reg = '0;
  logic [abag_pkg::MODE_W-1:0]          mode_reg = '0;

  logic [abag_pkg::IN_W-1:0] pixel_q[$];     // pixels waiting for the driver
  texel_addr_t               address_q[$];   // addresses owed by the block, oldest first
  int errors = 0;

  // Sender burst/gap state and receiver stall state.
  int burst_left = 0;
  int gap_left = 0;
  int ready_mode = 0;
  int mode_left = 0;
  int stall_left = 0;
  int ready_tick = 0;
  int idle_cycles = 0;

  affine_background_address_generator_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Wrap a scroll-minus-center difference the way the hardware does: keep the
  // low 10 bits and take bit 13 as the sign.
  function automatic longint wrap_offset(input longint n);
    longint low;
    low = n & FIELD_MASK;
    return n[13] ? low - 1024 : low;
  endfunction

  // Work out the address beat for one pixel under the shadow registers.
  function automatic texel_addr_t compute_address(
      input logic [abag_pkg::LINE_W-1:0] line,
      input logic [abag_pkg::COL_W-1:0]  column);
    texel_addr_t            r;
    longint                 a, b, c, d, hc, vc, ho, vo, msize;
    longint                 ln, cl, ly, y, x, dh, dv, ox, oy, px, py;
    logic                   mos, oob;
    abag_pkg::repeat_mode_t rpt;
    mos   = mode_reg[abag_pkg::MODE_MOSAIC];
    rpt   = abag_pkg::repeat_mode_t'(mode_reg[abag_pkg::MODE_RPT_LO +: 2]);
    msize = longint'(mode_reg[abag_pkg::MODE_SIZE_LO +: 4]) + 1;
    a  = mat_a;
    b  = mat_b;
    c  = mat_c;
    d  = mat_d;
    hc = ctr_h;
    vc = ctr_v;
    ho = $signed(scroll_reg[12:0]);
    vo = $signed(scroll_reg[25:13]);
    ln = line;
    cl = column;

    // Mosaic snaps the line down to its block, then the flips mirror it.
    ly = mos ? ln - ln % msize : ln;
    y  = mode_reg[abag_pkg::MODE_VFLIP] ? 255 - ly : ly;
    x  = mode_reg[abag_pkg::MODE_HFLIP] ? 255 - cl : cl;

    dh = wrap_offset(ho - hc);
    dv = wrap_offset(vo - vc);

    // Each partial product but the a*x and c*x terms drops its low six bits toward minus infinity.
    ox = ((a * dh) & ~LOW6_MASK) + ((b * dv) & ~LOW6_MASK) + ((b * y) & ~LOW6_MASK)
         + hc * 256;
    oy = ((c * dh) & ~LOW6_MASK) + ((d * dv) & ~LOW6_MASK) + ((d * y) & ~LOW6_MASK)
         + vc * 256;
    px = (ox + a * x) >>> 8;
    py = (oy + c * x) >>> 8;

    oob = ((px | py) & ~FIELD_MASK) != 0;
    r.map_address       = abag_pkg::MAP_W'(((py >> 3) & 127) * 128 + ((px >> 3) & 127));
    r.texel_index       = abag_pkg::TEXEL_W'(((py & 7) << 3) + (px & 7));
    r.out_of_bounds     = oob;
    r.use_tile_zero     = oob && rpt == abag_pkg::RPT_TILE_ZERO;
    r.force_transparent = oob && rpt == abag_pkg::RPT_TRANSPARENT;
    r.mosaic_sample     = !mos || (cl % msize == 0);
    return r;
  endfunction

  function automatic logic [abag_pkg::CFG_W-1:0] mode_word(
      input logic hf, input logic vf, input abag_pkg::repeat_mode_t rpt,
      input logic mos, input logic [3:0] size);
    logic [abag_pkg::CFG_W-1:0] w;
    w = '0;
    w[abag_pkg::MODE_HFLIP]         = hf;
    w[abag_pkg::MODE_VFLIP]         = vf;
    w[abag_pkg::MODE_RPT_LO +: 2]   = rpt;
    w[abag_pkg::MODE_MOSAIC]        = mos;
    w[abag_pkg::MODE_SIZE_LO +: 4]  = size;
    return w;
  endfunction

  // Matrix draw: full random (junk above bit 15 too), small signed, or an extreme.
  function automatic logic [abag_pkg::CFG_W-1:0] rand_matrix();
    case ($urandom_range(0, 2))
      0: return abag_pkg::CFG_W'($urandom());
      1: return abag_pkg::CFG_W'(int'($urandom_range(0, 1023)) - 512);
      default: begin
        case ($urandom_range(0, 3))
          0: return abag_pkg::CFG_W'(16'h8000);
          1: return abag_pkg::CFG_W'(16'h7FFF);
          2: return abag_pkg::CFG_W'(16'h0100);
          default: return abag_pkg::CFG_W'(16'hFF00);
        endcase
      end
    endcase
  endfunction

  // 13-bit signed draw for centers and scroll halves.
  function automatic logic [abag_pkg::CFG_W-1:0] rand_coord();
    case ($urandom_range(0, 2))
      0: return abag_pkg::CFG_W'($urandom());
      1: return abag_pkg::CFG_W'(int'($urandom_range(0, 511)) - 256);
      default: return $urandom_range(0, 1) ? abag_pkg::CFG_W'(13'h1000)
                                           : abag_pkg::CFG_W'(13'h0FFF);
    endcase
  endfunction

  // Write one register and mirror it in the shadow copy; hold the strobe one cycle.
  task automatic write_reg(input abag_pkg::cfg_reg_t idx,
                           input logic [abag_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      abag_pkg::REG_MATRIX_A: mat_a = val[abag_pkg::MATRIX_W-1:0];
      abag_pkg::REG_MATRIX_B: mat_b = val[abag_pkg::MATRIX_W-1:0];
      abag_pkg::REG_MATRIX_C: mat_c = val[abag_pkg::MATRIX_W-1:0];
      abag_pkg::REG_MATRIX_D: mat_d = val[abag_pkg::MATRIX_W-1:0];
      abag_pkg::REG_CENTER_H: ctr_h = val[abag_pkg::CENTER_W-1:0];
      abag_pkg::REG_CENTER_V: ctr_v = val[abag_pkg::CENTER_W-1:0];
      abag_pkg::REG_SCROLL:   scroll_reg = val[abag_pkg::SCROLL_W-1:0];
      abag_pkg::REG_MODE:     mode_reg = val[abag_pkg::MODE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_pixel(input logic [abag_pkg::LINE_W-1:0] line,
                            input logic [abag_pkg::COL_W-1:0] column);
    pixel_q.push_back({column, line});
  endtask

  // Hold until every queued pixel is sent and every address has come back, then
  // let the five-stage pipe settle before anything touches the registers.
  task automatic wait_idle();
    while (pixel_q.size() != 0 || s_tvalid || address_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: predict each accepted pixel beat, then present the next one. The
  // sender runs in bursts of 1..32 beats; half the gaps between bursts are zero,
  // which gives long unbroken stretches.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        address_q.push_back(compute_address(s_tdata[abag_pkg::LINE_W-1:0],
                                            s_tdata[abag_pkg::IN_W-1:abag_pkg::LINE_W]));
      end
      // Only advance once the current beat has gone; otherwise hold it.
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          s_tdata  <= pixel_q.pop_front();
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each address beat against the oldest prediction, then pick
  // the next m_tready. The stall style is redrawn at random between
  // always ready, coin flip, a 3-of-4 cadence and occasional long stalls.
  always @(posedge clk) begin
    texel_addr_t want;
    logic        nxt_ready;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (address_q.size() == 0) begin
          $display("%0t ns: unexpected address beat, expected none, actual %h", $time,
                   m_tdata);
          errors++;
        end else begin
          want = address_q.pop_front();
          check_field("map_address", 32'(want.map_address), 32'(m_tdata[13:0]));
          check_field("texel_index", 32'(want.texel_index), 32'(m_tdata[19:14]));
          check_field("out_of_bounds", 32'(want.out_of_bounds), 32'(m_tdata[20]));
          check_field("use_tile_zero", 32'(want.use_tile_zero), 32'(m_tdata[21]));
          check_field("force_transparent", 32'(want.force_transparent), 32'(m_tdata[22]));
          check_field("mosaic_sample", 32'(want.mosaic_sample), 32'(m_tdata[23]));
        end
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(64, 256);
      end else begin
        mode_left--;
      end
      ready_tick++;
      case (ready_mode)
        0: nxt_ready = 1'b1;
        1: nxt_ready = 1'($urandom_range(0, 1));
        2: nxt_ready = (ready_tick % 4) != 3;
        default: begin
          if (stall_left != 0) begin
            stall_left--;
            nxt_ready = 1'b0;
          end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(4, 12);
            nxt_ready  = 1'b0;
          end else begin
            nxt_ready = 1'b1;
          end
        end
      endcase
      m_tready <= nxt_ready;
    end
  end

  // Watchdog: drop the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[affine_background_address_generator_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed phases first, then random register sets with mostly
  // scanline runs of consecutive columns, the way a display walks the screen.
  initial begin
    int                          sent;
    int                          run;
    bit                          paused;
    logic [abag_pkg::LINE_W-1:0] line;
    logic [abag_pkg::COL_W-1:0]  col;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Registers at their reset value: everything folds onto the origin.
    push_pixel(8'd0, 8'd0);
    push_pixel(8'd255, 8'd255);
    push_pixel(8'd0, 8'd255);
    push_pixel(8'd255, 8'd0);
    wait_idle();

    // Identity mapping, no flips, no mosaic.
    write_reg(abag_pkg::REG_MATRIX_A, 26'h0100);
    write_reg(abag_pkg::REG_MATRIX_D, 26'h0100);
    push_pixel(8'd0, 8'd0);
    push_pixel(8'd255, 8'd255);
    push_pixel(8'h55, 8'hAA);
    push_pixel(8'hAA, 8'h55);
    wait_idle();

    // Both flips with the largest mosaic block.
    write_reg(abag_pkg::REG_MODE, mode_word(1'b1, 1'b1, abag_pkg::RPT_WRAP0, 1'b1, 4'd15));
    push_pixel(8'd17, 8'd16);
    push_pixel(8'd31, 8'd47);
    push_pixel(8'd255, 8'd0);
    push_pixel(8'd1, 8'd1);
    wait_idle();

    // Extremes of every register; out of bounds falls back to tile zero.
    write_reg(abag_pkg::REG_MATRIX_A, 26'h8000);
    write_reg(abag_pkg::REG_MATRIX_B, 26'h7FFF);
    write_reg(abag_pkg::REG_MATRIX_C, 26'h7FFF);
    write_reg(abag_pkg::REG_MATRIX_D, 26'h8000);
    write_reg(abag_pkg::REG_CENTER_H, 26'h1000);
    write_reg(abag_pkg::REG_CENTER_V, 26'h0FFF);
    write_reg(abag_pkg::REG_SCROLL, 26'h3FFFFFF);
    write_reg(abag_pkg::REG_MODE,
              mode_word(1'b0, 1'b0, abag_pkg::RPT_TILE_ZERO, 1'b0, 4'd0));
    push_pixel(8'd0, 8'd0);
    push_pixel(8'd255, 8'd255);
    push_pixel(8'd128, 8'd1);
    push_pixel(8'd7, 8'd200);
    wait_idle();

    // Transparent repeat mode with the largest positive scroll.
    write_reg(abag_pkg::REG_MATRIX_A, 26'h7FFF);
    write_reg(abag_pkg::REG_MATRIX_B, 26'h0000);
    write_reg(abag_pkg::REG_MATRIX_C, 26'h0000);
    write_reg(abag_pkg::REG_MATRIX_D, 26'h0100);
    write_reg(abag_pkg::REG_CENTER_H, 26'h0000);
    write_reg(abag_pkg::REG_CENTER_V, 26'h0000);
    write_reg(abag_pkg::REG_SCROLL, 26'h0FFF);
    write_reg(abag_pkg::REG_MODE,
              mode_word(1'b0, 1'b0, abag_pkg::RPT_TRANSPARENT, 1'b0, 4'd0));
    push_pixel(8'd0, 8'd0);
    push_pixel(8'd0, 8'd1);
    push_pixel(8'd100, 8'd255);
    push_pixel(8'd255, 8'd128);
    wait_idle();

    // Wrapping repeat mode off the left edge; mosaic on with block size one.
    write_reg(abag_pkg::REG_MATRIX_A, 26'h0100);
    write_reg(abag_pkg::REG_SCROLL, 26'h1FF8);
    write_reg(abag_pkg::REG_MODE, mode_word(1'b0, 1'b0, abag_pkg::RPT_WRAP1, 1'b1, 4'd0));
    push_pixel(8'd0, 8'd0);
    push_pixel(8'd3, 8'd7);
    push_pixel(8'd9, 8'd8);
    push_pixel(8'd255, 8'd64);
    wait_idle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(abag_pkg::REG_MATRIX_A, rand_matrix());
      write_reg(abag_pkg::REG_MATRIX_B, rand_matrix());
      write_reg(abag_pkg::REG_MATRIX_C, rand_matrix());
      write_reg(abag_pkg::REG_MATRIX_D, rand_matrix());
      write_reg(abag_pkg::REG_CENTER_H, rand_coord());
      write_reg(abag_pkg::REG_CENTER_V, rand_coord());
      write_reg(abag_pkg::REG_SCROLL, (rand_coord() << 13) | (rand_coord() & 26'h1FFF));
      write_reg(abag_pkg::REG_MODE, abag_pkg::CFG_W'($urandom()));
      sent = 0;
      while (sent < PHASE_PIXELS) begin
        // Midway through one phase, hold the sender until the pipe drains.
        if (ph == RANDOM_PHASES / 2 && sent >= PHASE_PIXELS / 2 && !paused) begin
          wait_idle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 3) != 0) begin
          line = abag_pkg::LINE_W'($urandom());
          col  = abag_pkg::COL_W'($urandom());
          run  = $urandom_range(4, 24);
          for (int k = 0; k < run; k++) push_pixel(line, col + abag_pkg::COL_W'(k));
          sent += run;
        end else begin
          push_pixel(abag_pkg::LINE_W'($urandom()), abag_pkg::COL_W'($urandom()));
          sent++;
        end
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[affine_background_address_generator_core] OK");
    end else begin
      $display("[affine_background_address_generator_core] ERROR");
    end
    $finish;
  end

endmodule
